[rtl/core/rdbd_pkg.sv]
// ----------------------------------------------------------------------------
// rdbd_pkg
// Shared types and constants of the ray delta bin decoder.
// ----------------------------------------------------------------------------
package rdbd_pkg;

  localparam int DATA_W    = 32;
  localparam int SCALE_W   = 17;
  localparam int BCOUNT_W  = 11;
  localparam int BIN_W     = 10;
  localparam int CODE_W    = 16;
  localparam int FRAC_W    = 16;
  localparam int PROD_W    = 50;
  localparam int SUM_W     = 51;
  localparam int REG_IDX_W = 3;
  localparam int PADDR_W   = 5;

  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = 2;
  localparam int QCNT_W      = 3;

  localparam logic [REG_IDX_W-1:0] REG_SCALE_STEP   = 3'd0;
  localparam logic [REG_IDX_W-1:0] REG_BIN_COUNT    = 3'd1;
  localparam logic [REG_IDX_W-1:0] REG_VALUE_GAIN   = 3'd2;
  localparam logic [REG_IDX_W-1:0] REG_VALUE_OFFSET = 3'd3;
  localparam logic [REG_IDX_W-1:0] REG_SPECIAL_0    = 3'd4;
  localparam logic [REG_IDX_W-1:0] REG_SPECIAL_1    = 3'd5;
  localparam logic [REG_IDX_W-1:0] REG_SPECIAL_2    = 3'd6;
  localparam logic [REG_IDX_W-1:0] REG_NO_DATA      = 3'd7;

  localparam logic [SCALE_W-1:0]  SCALE_RESET  = 17'd65536;
  localparam logic [BCOUNT_W-1:0] BCOUNT_RESET = 11'd1000;
  localparam logic [DATA_W-1:0]   GAIN_RESET   = 32'd65536;

  localparam logic signed [DATA_W-1:0] VAL_MAX = 32'sh7FFF_FFFF;
  localparam logic signed [DATA_W-1:0] VAL_MIN = 32'sh8000_0000;

  localparam logic [1:0] SPECIAL_CODE_0 = 2'd0;
  localparam logic [1:0] SPECIAL_CODE_1 = 2'd1;
  localparam logic [CODE_W-1:0] SPECIAL_LIMIT = 16'd3;
  localparam logic [CODE_W:0]   CODE_BIAS     = 17'd3;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       ray_start;
    logic       ray_end;
    logic       clear_range;
  } in_item_t;

  typedef struct packed {
    logic [BIN_W-1:0]         bin_index;
    logic signed [DATA_W-1:0] bin_value;
    logic                     is_special;
    logic                     run_last;
    logic signed [DATA_W-1:0] range_min;
    logic signed [DATA_W-1:0] range_max;
  } out_item_t;

  typedef struct packed {
    logic [7:0]        data_byte;
    logic              ray_start;
    logic              ray_end;
    logic              clear_range;
    logic              esc_mark;
    logic [CODE_W-1:0] delta;
  } cmd_t;

  typedef struct packed {
    logic [SCALE_W-1:0]       scale_step;
    logic [BCOUNT_W-1:0]      bin_count;
    logic signed [DATA_W-1:0] value_gain;
    logic signed [DATA_W-1:0] value_offset;
    logic signed [DATA_W-1:0] special_value_0;
    logic signed [DATA_W-1:0] special_value_1;
    logic signed [DATA_W-1:0] special_value_2;
    logic signed [DATA_W-1:0] no_data_value;
  } cfg_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_GROUP,
    ST_SUM,
    ST_FIX,
    ST_RANGE,
    ST_EMIT
  } rdbd_state_e;

endpackage

[rtl/core/ray_delta_bin_decoder_unit.sv]
// ----------------------------------------------------------------------------
// ray_delta_bin_decoder_unit
// Radar ray decoder: escape and delta codes to scaled Q16.16 range bins.
// ----------------------------------------------------------------------------
// A byte passes the input register and the queue, then the decoder states
//   GROUP, SUM, FIX, RANGE and EMIT (GROUP and EMIT alone for a special code).
// The decoder pops no byte until the last bin of the one before is emitted;
//   escape lead and dropped bytes are handled in the idle state alone.
// The four-entry queue lets input bytes keep arriving while bins are emitted.
// Reset: asynchronous, active low; clears ray state, range tracking, queue,
//   and loads the register defaults.
module ray_delta_bin_decoder_unit #(
  parameter int MAX_BINS   = 1024,
  parameter int MAX_REPEAT = 16
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               in_valid_i,
  output logic                               in_ready_o,
  input  rdbd_pkg::in_item_t                 in_data_i,
  output logic                               out_valid_o,
  input  logic                               out_ready_i,
  output rdbd_pkg::out_item_t                out_data_o,
  input  logic                               psel,
  input  logic                               penable,
  input  logic                               pwrite,
  input  logic [rdbd_pkg::PADDR_W-1:0]       paddr,
  input  logic [rdbd_pkg::DATA_W-1:0]        pwdata,
  output logic [rdbd_pkg::DATA_W-1:0]        prdata,
  output logic                               pready
);

  rdbd_pkg::cfg_t                 cfg_q, cfg_d;
  logic                           cfg_we;
  logic [rdbd_pkg::REG_IDX_W-1:0] reg_idx;

  logic           push_valid, push_ready;
  rdbd_pkg::cmd_t push_data;
  logic           pop_valid, pop_ready;
  rdbd_pkg::cmd_t pop_data;

  assign pready  = 1'b1;
  assign reg_idx = paddr[rdbd_pkg::PADDR_W-1:2];
  assign cfg_we  = psel && penable && pwrite && pready;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we) begin
      unique case (reg_idx)
        rdbd_pkg::REG_SCALE_STEP:   cfg_d.scale_step      = pwdata[rdbd_pkg::SCALE_W-1:0];
        rdbd_pkg::REG_BIN_COUNT:    cfg_d.bin_count       = pwdata[rdbd_pkg::BCOUNT_W-1:0];
        rdbd_pkg::REG_VALUE_GAIN:   cfg_d.value_gain      = pwdata;
        rdbd_pkg::REG_VALUE_OFFSET: cfg_d.value_offset    = pwdata;
        rdbd_pkg::REG_SPECIAL_0:    cfg_d.special_value_0 = pwdata;
        rdbd_pkg::REG_SPECIAL_1:    cfg_d.special_value_1 = pwdata;
        rdbd_pkg::REG_SPECIAL_2:    cfg_d.special_value_2 = pwdata;
        rdbd_pkg::REG_NO_DATA:      cfg_d.no_data_value   = pwdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      rdbd_pkg::REG_SCALE_STEP:   prdata = rdbd_pkg::DATA_W'(cfg_q.scale_step);
      rdbd_pkg::REG_BIN_COUNT:    prdata = rdbd_pkg::DATA_W'(cfg_q.bin_count);
      rdbd_pkg::REG_VALUE_GAIN:   prdata = cfg_q.value_gain;
      rdbd_pkg::REG_VALUE_OFFSET: prdata = cfg_q.value_offset;
      rdbd_pkg::REG_SPECIAL_0:    prdata = cfg_q.special_value_0;
      rdbd_pkg::REG_SPECIAL_1:    prdata = cfg_q.special_value_1;
      rdbd_pkg::REG_SPECIAL_2:    prdata = cfg_q.special_value_2;
      rdbd_pkg::REG_NO_DATA:      prdata = cfg_q.no_data_value;
      default:                    prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.scale_step      <= rdbd_pkg::SCALE_RESET;
      cfg_q.bin_count       <= rdbd_pkg::BCOUNT_RESET;
      cfg_q.value_gain      <= rdbd_pkg::GAIN_RESET;
      cfg_q.value_offset    <= '0;
      cfg_q.special_value_0 <= '0;
      cfg_q.special_value_1 <= '0;
      cfg_q.special_value_2 <= '0;
      cfg_q.no_data_value   <= '0;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  rdbd_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .in_data_i    (in_data_i),
    .push_valid_o (push_valid),
    .push_ready_i (push_ready),
    .push_data_o  (push_data)
  );

  rdbd_queue u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (push_valid),
    .push_ready_o (push_ready),
    .push_data_i  (push_data),
    .pop_valid_o  (pop_valid),
    .pop_ready_i  (pop_ready),
    .pop_data_o   (pop_data)
  );

  rdbd_back #(
    .MAX_BINS   (MAX_BINS),
    .MAX_REPEAT (MAX_REPEAT)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .pop_valid_i (pop_valid),
    .pop_ready_o (pop_ready),
    .pop_data_i  (pop_data),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

`ifndef NO_ASSERTIONS
  a_special_source: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.is_special |->
      (out_data_o.bin_value == cfg_q.special_value_0) ||
      (out_data_o.bin_value == cfg_q.special_value_1) ||
      (out_data_o.bin_value == cfg_q.special_value_2))
    else $error("special bin value not from a special register");

  a_no_data_avoided: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_data_o.is_special |->
      out_data_o.bin_value != cfg_q.no_data_value)
    else $error("ordinary bin value equals the no-data marker");

  a_run_continues: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_ready_i && !out_data_o.run_last |=> out_valid_o)
    else $error("bin run interrupted before its last bin");
`endif

endmodule

[rtl/core/rdbd_front.sv]
// ----------------------------------------------------------------------------
// rdbd_front
// Input stage: takes encoded bytes and tags escape leads and signed deltas.
// ----------------------------------------------------------------------------
module rdbd_front (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  rdbd_pkg::in_item_t in_data_i,
  output logic              push_valid_o,
  input  logic              push_ready_i,
  output rdbd_pkg::cmd_t    push_data_o
);

  logic           cmd_valid_q, cmd_valid_d;
  rdbd_pkg::cmd_t cmd_q, cmd_d;
  logic           take;

  assign in_ready_o   = !cmd_valid_q || push_ready_i;
  assign take         = in_valid_i && in_ready_o;
  assign push_valid_o = cmd_valid_q;
  assign push_data_o  = cmd_q;

  always_comb begin
    cmd_valid_d = cmd_valid_q;
    if (push_ready_i) begin
      cmd_valid_d = 1'b0;
    end
    if (take) begin
      cmd_valid_d = 1'b1;
    end
    cmd_d.data_byte   = in_data_i.data_byte;
    cmd_d.ray_start   = in_data_i.ray_start;
    cmd_d.ray_end     = in_data_i.ray_end;
    cmd_d.clear_range = in_data_i.clear_range;
    cmd_d.esc_mark    = in_data_i.data_byte[7];
    cmd_d.delta       = {{(rdbd_pkg::CODE_W-7){in_data_i.data_byte[6]}},
                         in_data_i.data_byte[6:0]};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cmd_valid_q <= 1'b0;
    end else begin
      cmd_valid_q <= cmd_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      cmd_q <= cmd_d;
    end
  end

endmodule

[rtl/core/rdbd_queue.sv]
// ----------------------------------------------------------------------------
// rdbd_queue
// Small FIFO of tagged bytes between the input stage and the decoder.
// ----------------------------------------------------------------------------
module rdbd_queue (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_valid_i,
  output logic           push_ready_o,
  input  rdbd_pkg::cmd_t push_data_i,
  output logic           pop_valid_o,
  input  logic           pop_ready_i,
  output rdbd_pkg::cmd_t pop_data_o
);

  rdbd_pkg::cmd_t                    mem_q [rdbd_pkg::QUEUE_DEPTH];
  logic [rdbd_pkg::QPTR_W-1:0]       wr_ptr_q, wr_ptr_d;
  logic [rdbd_pkg::QPTR_W-1:0]       rd_ptr_q, rd_ptr_d;
  logic [rdbd_pkg::QCNT_W-1:0]       cnt_q, cnt_d;
  logic                              push, pop;

  assign push_ready_o = (cnt_q != rdbd_pkg::QCNT_W'(rdbd_pkg::QUEUE_DEPTH));
  assign pop_valid_o  = (cnt_q != '0);
  assign pop_data_o   = mem_q[rd_ptr_q];
  assign push         = push_valid_i && push_ready_o;
  assign pop          = pop_valid_o && pop_ready_i;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (push) begin
      wr_ptr_d = wr_ptr_q + 1'b1;
    end
    if (pop) begin
      rd_ptr_d = rd_ptr_q + 1'b1;
    end
    if (push && !pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (pop && !push) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

endmodule

[rtl/core/rdbd_back.sv]
// ----------------------------------------------------------------------------
// rdbd_back
// Decoder: running code, value scaling, range tracking and bin emission.
// ----------------------------------------------------------------------------
module rdbd_back #(
  parameter int MAX_BINS   = 1024,
  parameter int MAX_REPEAT = 16
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  rdbd_pkg::cfg_t     cfg_i,
  input  logic               pop_valid_i,
  output logic               pop_ready_o,
  input  rdbd_pkg::cmd_t     pop_data_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output rdbd_pkg::out_item_t out_data_o
);

  localparam int NbW  = $clog2(MAX_BINS + 1);
  localparam int AccW = NbW + rdbd_pkg::SCALE_W;
  localparam int GrpW = AccW - rdbd_pkg::FRAC_W;
  localparam int CntW = $clog2(MAX_REPEAT + 1);
  localparam int LimW = (NbW > rdbd_pkg::BCOUNT_W) ? NbW : rdbd_pkg::BCOUNT_W;

  rdbd_pkg::rdbd_state_e state_q, state_d;

  logic [rdbd_pkg::CODE_W-1:0]       code_q, code_d;
  logic                              esc_q, esc_d;
  logic [6:0]                        esc_hi_q, esc_hi_d;
  logic [NbW-1:0]                    next_bin_q, next_bin_d;
  logic                              fin_q, fin_d;
  logic signed [rdbd_pkg::DATA_W-1:0] min_q, min_d;
  logic signed [rdbd_pkg::DATA_W-1:0] max_q, max_d;
  logic [CntW-1:0]                   cnt_q, cnt_d;
  logic                              out_valid_q, out_valid_d;

  logic                              last_q, last_d;
  logic                              special_q, special_d;
  logic signed [rdbd_pkg::PROD_W-1:0] prod_q, prod_d;
  logic signed [rdbd_pkg::DATA_W-1:0] val_q, val_d;
  logic [AccW-1:0]                   acc_q, acc_d;
  logic [GrpW-1:0]                   group_q, group_d;
  rdbd_pkg::out_item_t               out_q, out_d;

  logic [LimW-1:0]                   bc_ext, max_ext, limit_full;
  logic [NbW-1:0]                    limit;
  logic [rdbd_pkg::CODE_W-1:0]       cur_code;
  logic                              cur_esc;
  logic [6:0]                        cur_hi;
  logic [NbW-1:0]                    cur_nb;
  logic                              cur_fin;
  logic                              drop;
  logic [rdbd_pkg::CODE_W:0]         code_bias;
  logic signed [rdbd_pkg::CODE_W+1:0] mul_a;
  logic [AccW-1:0]                   grp_prod;
  logic signed [rdbd_pkg::SUM_W-1:0] sum_w;
  logic                              sum_ovf;
  logic [NbW-1:0]                    nb_inc;
  logic [AccW-1:0]                   acc_inc;
  logic [CntW-1:0]                   cnt_inc;
  logic                              stop;
  logic                              slot_free;
  logic [NbW+rdbd_pkg::BIN_W-1:0]    nb_wide;

  assign bc_ext      = LimW'(cfg_i.bin_count);
  assign max_ext     = LimW'(MAX_BINS);
  assign limit_full  = (bc_ext > max_ext) ? max_ext : bc_ext;
  assign limit       = limit_full[NbW-1:0];
  assign pop_ready_o = (state_q == rdbd_pkg::ST_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;
  assign slot_free   = !out_valid_q || out_ready_i;

  assign code_bias = {1'b0, code_q} + rdbd_pkg::CODE_BIAS;
  assign mul_a     = {1'b0, code_bias};
  assign grp_prod  = AccW'(next_bin_q) * AccW'(cfg_i.scale_step);

  assign sum_w   = {prod_q[rdbd_pkg::PROD_W-1], prod_q}
                 + {{(rdbd_pkg::SUM_W-rdbd_pkg::DATA_W){cfg_i.value_offset[rdbd_pkg::DATA_W-1]}},
                    cfg_i.value_offset};
  assign sum_ovf = !((&sum_w[rdbd_pkg::SUM_W-1:rdbd_pkg::DATA_W-1])
                  || !(|sum_w[rdbd_pkg::SUM_W-1:rdbd_pkg::DATA_W-1]));

  assign nb_inc  = next_bin_q + 1'b1;
  assign acc_inc = acc_q + AccW'(cfg_i.scale_step);
  assign cnt_inc = cnt_q + 1'b1;
  assign nb_wide = {{rdbd_pkg::BIN_W{1'b0}}, next_bin_q};
  assign stop    = last_q || (cnt_inc >= CntW'(MAX_REPEAT)) || (nb_inc >= limit)
                || (acc_inc[AccW-1:rdbd_pkg::FRAC_W] != group_q);

  always_comb begin
    cur_code = pop_data_i.ray_start ? '0 : code_q;
    cur_esc  = pop_data_i.ray_start ? 1'b0 : esc_q;
    cur_hi   = pop_data_i.ray_start ? '0 : esc_hi_q;
    cur_nb   = pop_data_i.ray_start ? '0 : next_bin_q;
    cur_fin  = pop_data_i.ray_start ? 1'b0 : fin_q;
    drop     = cur_fin || (cur_nb >= limit);

    state_d     = state_q;
    code_d      = code_q;
    esc_d       = esc_q;
    esc_hi_d    = esc_hi_q;
    next_bin_d  = next_bin_q;
    fin_d       = fin_q;
    min_d       = min_q;
    max_d       = max_q;
    cnt_d       = cnt_q;
    out_valid_d = out_valid_q;
    last_d      = last_q;
    special_d   = special_q;
    prod_d      = prod_q;
    val_d       = val_q;
    acc_d       = acc_q;
    group_d     = group_q;
    out_d       = out_q;

    if (out_ready_i) begin
      out_valid_d = 1'b0;
    end

    unique case (state_q)
      rdbd_pkg::ST_IDLE: begin
        if (pop_valid_i) begin
          code_d     = cur_code;
          esc_d      = cur_esc;
          esc_hi_d   = cur_hi;
          next_bin_d = cur_nb;
          fin_d      = cur_fin;
          last_d     = pop_data_i.ray_end;
          if (pop_data_i.clear_range) begin
            min_d = rdbd_pkg::VAL_MAX;
            max_d = rdbd_pkg::VAL_MIN;
          end
          if (!drop) begin
            if (cur_esc) begin
              code_d  = {1'b0, cur_hi, pop_data_i.data_byte};
              esc_d   = 1'b0;
              state_d = rdbd_pkg::ST_GROUP;
            end else if (pop_data_i.esc_mark) begin
              if (pop_data_i.ray_end) begin
                fin_d = 1'b1;
              end else begin
                esc_d    = 1'b1;
                esc_hi_d = pop_data_i.data_byte[6:0];
              end
            end else begin
              code_d  = cur_code + pop_data_i.delta;
              state_d = rdbd_pkg::ST_GROUP;
            end
          end
        end
      end
      rdbd_pkg::ST_GROUP: begin
        special_d = (code_q < rdbd_pkg::SPECIAL_LIMIT);
        prod_d    = mul_a * cfg_i.value_gain;
        acc_d     = grp_prod;
        group_d   = grp_prod[AccW-1:rdbd_pkg::FRAC_W];
        cnt_d     = '0;
        unique case (code_q[1:0])
          rdbd_pkg::SPECIAL_CODE_0: val_d = cfg_i.special_value_0;
          rdbd_pkg::SPECIAL_CODE_1: val_d = cfg_i.special_value_1;
          default:                  val_d = cfg_i.special_value_2;
        endcase
        state_d = special_d ? rdbd_pkg::ST_EMIT : rdbd_pkg::ST_SUM;
      end
      rdbd_pkg::ST_SUM: begin
        if (sum_ovf) begin
          val_d = sum_w[rdbd_pkg::SUM_W-1] ? rdbd_pkg::VAL_MIN : rdbd_pkg::VAL_MAX;
        end else begin
          val_d = sum_w[rdbd_pkg::DATA_W-1:0];
        end
        state_d = rdbd_pkg::ST_FIX;
      end
      rdbd_pkg::ST_FIX: begin
        if (val_q == cfg_i.no_data_value) begin
          val_d = (val_q == rdbd_pkg::VAL_MAX) ? val_q - 1'b1 : val_q + 1'b1;
        end
        state_d = rdbd_pkg::ST_RANGE;
      end
      rdbd_pkg::ST_RANGE: begin
        if ((val_q != '0) && (val_q < min_q)) begin
          min_d = val_q;
        end
        if (val_q > max_q) begin
          max_d = val_q;
        end
        state_d = rdbd_pkg::ST_EMIT;
      end
      rdbd_pkg::ST_EMIT: begin
        if (slot_free) begin
          out_valid_d      = 1'b1;
          out_d.bin_index  = nb_wide[rdbd_pkg::BIN_W-1:0];
          out_d.bin_value  = val_q;
          out_d.is_special = special_q;
          out_d.run_last   = stop;
          out_d.range_min  = min_q;
          out_d.range_max  = max_q;
          next_bin_d       = nb_inc;
          acc_d            = acc_inc;
          cnt_d            = cnt_inc;
          if (stop) begin
            fin_d   = last_q;
            state_d = rdbd_pkg::ST_IDLE;
          end
        end
      end
      default: begin
        state_d = rdbd_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= rdbd_pkg::ST_IDLE;
      code_q      <= '0;
      esc_q       <= 1'b0;
      esc_hi_q    <= '0;
      next_bin_q  <= '0;
      fin_q       <= 1'b0;
      min_q       <= rdbd_pkg::VAL_MAX;
      max_q       <= rdbd_pkg::VAL_MIN;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      code_q      <= code_d;
      esc_q       <= esc_d;
      esc_hi_q    <= esc_hi_d;
      next_bin_q  <= next_bin_d;
      fin_q       <= fin_d;
      min_q       <= min_d;
      max_q       <= max_d;
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    last_q    <= last_d;
    special_q <= special_d;
    prod_q    <= prod_d;
    val_q     <= val_d;
    acc_q     <= acc_d;
    group_q   <= group_d;
    out_q     <= out_d;
  end

endmodule
